### hdl/pott_pkg.sv
// ----------------------------------------------------------------------------
// pott_pkg
// Shared types and constants for the priority-ordered task table.
// ----------------------------------------------------------------------------
package pott_pkg;

  localparam int unsigned KeyBits      = 16;
  localparam int unsigned PrioBits     = 8;
  localparam int unsigned DepthDefault = 16;

  typedef enum logic [1:0] {
    CmdInsert   = 2'd0,
    CmdList     = 2'd1,
    CmdComplete = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StListed   = 3'd1,
    StNone     = 3'd2,
    StNotFound = 3'd3,
    StFull     = 3'd4
  } status_e;

  typedef struct packed {
    cmd_e                command;
    logic [KeyBits-1:0]  task_id;
    logic [PrioBits-1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [KeyBits-1:0]  task_id_res;
    logic [PrioBits-1:0] task_priority;
    status_e             status;
    logic                last;
  } res_t;

  // one table entry as held in memory
  typedef struct packed {
    logic [KeyBits-1:0]  key;
    logic [PrioBits-1:0] prio;
  } entry_t;

endpackage

### hdl/priority_ordered_task_table.sv
// ----------------------------------------------------------------------------
// priority_ordered_task_table
// Table of up to DEPTH tasks (key, priority) kept in falling priority order.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start_i is high and busy_o is low. req_i carries
//   the command (insert, list, complete), the key and the priority.
//   Each result appears on res_o for one cycle with res_valid_o high; the
//   receiver cannot stall, so results simply stream out. res_o.last marks
//   the final result of a request, and busy_o, where it rose, falls on that same edge.
// Operation:
//   The table lives in one synchronous memory (registered read). A command
//   walks it one entry per cycle through the single read port, unless it is
//   answered at once (insert into a full table, list or complete on an empty
//   one). Insert: move lower-priority entries up one place from the top, then
//   write the new task into the slot (full table: result the cycle after the
//   request). List: results on the way out as matches are confirmed.
//   Complete: walk to the match, then close the gap.
// Reset:
//   rst_ni clears the entry count and control state only; the memory is not
//   cleared, entries at or above the count are never used. Unused command
//   codes are dropped without a result.
// ----------------------------------------------------------------------------
module priority_ordered_task_table #(
  parameter int unsigned DEPTH = pott_pkg::DepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  pott_pkg::req_t  req_i,
  output logic            res_valid_o,
  output pott_pkg::res_t  res_o
);
  import pott_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS      = 3'd1; // shift entries up, find slot
  localparam logic [2:0] S_INS_WR   = 3'd2; // drop new task into slot
  localparam logic [2:0] S_FIND     = 3'd3; // search key for complete
  localparam logic [2:0] S_SHIFT    = 3'd4; // close gap after removal
  localparam logic [2:0] S_LIST     = 3'd5; // walk and hold one match back
  localparam logic [2:0] S_LIST_END = 3'd6; // flush held match or none

  logic [2:0]          state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [KeyBits-1:0]  key_q, key_d;
  logic [PrioBits-1:0] prio_q, prio_d;
  entry_t              pend_q, pend_d;
  logic                pend_vld_q, pend_vld_d;
  res_t                res_q, res_d;
  logic                res_vld_q, res_vld_d;

  // table memory, one read and one write port
  entry_t              mem [DEPTH];
  entry_t              rd_data_q;
  logic [IdxW-1:0]     mem_ra;
  logic                mem_we;
  logic [IdxW-1:0]     mem_wa;
  entry_t              mem_wd;

  logic                accept;
  logic [CntW-1:0]     idx_ext;
  logic                at_last;
  logic                shift_end;
  logic                prio_hit;
  logic                key_hit;

  assign accept    = start_i && (state_q == S_IDLE);
  assign idx_ext   = CntW'(idx_q);
  assign at_last   = (idx_ext == cnt_q - CntW'(1));
  assign shift_end = (idx_ext + CntW'(2) == cnt_q);
  assign prio_hit  = (rd_data_q.prio >= prio_q);
  assign key_hit   = (rd_data_q.key == key_q);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    key_d      = key_q;
    prio_d     = prio_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    res_d      = res_q;
    res_vld_d  = 1'b0;
    mem_ra     = idx_q + IdxW'(1);
    mem_we     = 1'b0;
    mem_wa     = idx_q;
    mem_wd     = rd_data_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d  = req_i.task_id;
          prio_d = req_i.priority_req;
          idx_d  = '0;
          mem_ra = '0;
          unique case (req_i.command)
            CmdInsert: begin
              if (cnt_q == CntW'(DEPTH)) begin
                res_d     = '{task_id_res: req_i.task_id, task_priority: req_i.priority_req,
                              status: StFull, last: 1'b1};
                res_vld_d = 1'b1;
              end else if (cnt_q == '0) begin
                state_d = S_INS_WR;
              end else begin
                idx_d   = IdxW'(cnt_q);
                mem_ra  = IdxW'(cnt_q - CntW'(1));
                state_d = S_INS;
              end
            end
            CmdList: begin
              pend_vld_d = 1'b0;
              if (cnt_q == '0) begin
                res_d     = '{task_id_res: '0, task_priority: '0,
                              status: StNone, last: 1'b1};
                res_vld_d = 1'b1;
              end else begin
                state_d = S_LIST;
              end
            end
            CmdComplete: begin
              if (cnt_q == '0) begin
                res_d     = '{task_id_res: req_i.task_id, task_priority: '0,
                              status: StNotFound, last: 1'b1};
                res_vld_d = 1'b1;
              end else begin
                state_d = S_FIND;
              end
            end
            default: ; // unused code, dropped
          endcase
        end
      end

      S_INS: begin
        // rd_data_q holds entry idx_q-1
        mem_we = 1'b1;
        if (prio_hit) begin
          mem_wd    = '{key: key_q, prio: prio_q};
          res_d     = '{task_id_res: key_q, task_priority: prio_q,
                        status: StOk, last: 1'b1};
          res_vld_d = 1'b1;
          cnt_d     = cnt_q + CntW'(1);
          state_d   = S_IDLE;
        end else begin
          idx_d  = idx_q - IdxW'(1);
          mem_ra = idx_q - IdxW'(2);
          if (idx_q == IdxW'(1)) begin
            state_d = S_INS_WR;
          end
        end
      end

      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_wd    = '{key: key_q, prio: prio_q};
        res_d     = '{task_id_res: key_q, task_priority: prio_q,
                      status: StOk, last: 1'b1};
        res_vld_d = 1'b1;
        cnt_d     = cnt_q + CntW'(1);
        state_d   = S_IDLE;
      end

      S_FIND: begin
        // rd_data_q holds entry idx_q; next entry read ahead
        if (key_hit) begin
          if (at_last) begin
            res_d     = '{task_id_res: rd_data_q.key, task_priority: rd_data_q.prio,
                          status: StOk, last: 1'b1};
            res_vld_d = 1'b1;
            cnt_d     = cnt_q - CntW'(1);
            state_d   = S_IDLE;
          end else begin
            // keep the removed entry, reported once the gap is closed
            pend_d  = rd_data_q;
            state_d = S_SHIFT;
          end
        end else if (at_last) begin
          res_d     = '{task_id_res: key_q, task_priority: '0,
                        status: StNotFound, last: 1'b1};
          res_vld_d = 1'b1;
          state_d   = S_IDLE;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end

      S_SHIFT: begin
        // rd_data_q holds entry idx_q+1, moved down one place
        mem_we = 1'b1;
        mem_ra = idx_q + IdxW'(2);
        if (shift_end) begin
          res_d     = '{task_id_res: pend_q.key, task_priority: pend_q.prio,
                        status: StOk, last: 1'b1};
          res_vld_d = 1'b1;
          cnt_d     = cnt_q - CntW'(1);
          state_d   = S_IDLE;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end

      S_LIST: begin
        if (prio_hit) begin
          if (pend_vld_q) begin
            res_d     = '{task_id_res: pend_q.key, task_priority: pend_q.prio,
                          status: StListed, last: 1'b0};
            res_vld_d = 1'b1;
          end
          pend_d     = rd_data_q;
          pend_vld_d = 1'b1;
        end
        if (at_last) begin
          state_d = S_LIST_END;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end

      S_LIST_END: begin
        if (pend_vld_q) begin
          res_d = '{task_id_res: pend_q.key, task_priority: pend_q.prio,
                    status: StListed, last: 1'b1};
        end else begin
          res_d = '{task_id_res: '0, task_priority: '0, status: StNone, last: 1'b1};
        end
        res_vld_d = 1'b1;
        state_d   = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      res_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      res_vld_q  <= res_vld_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    key_q  <= key_d;
    prio_q <= prio_d;
    pend_q <= pend_d;
    res_q  <= res_d;
  end

  // table memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem[mem_ra];
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  // checks
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("entry count above table depth");

  a_res_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy_o || start_i))
    else $error("result without a request in progress");

  a_end_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> (res_valid_o && res_o.last))
    else $error("request ended without a final result");

  a_mid_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last) |-> busy_o)
    else $error("non-final result while idle");

endmodule
